@@ src/bft_pkg.sv @@
// Shared types, constants and the endpoint hash of the bidirectional flow table.
// Used by bft_ctrl, bft_datapath and bidirectional_flow_table; depends on nothing.
package bft_pkg;

  localparam int unsigned HashW = 16;
  localparam logic [HashW-1:0] HashMul = 16'd13;
  localparam int unsigned HashBytes = 6;
  localparam int unsigned BucketOutW = 10;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
  } in_beat_t;

  typedef struct packed {
    logic [31:0]           flow_id;
    logic                  created;
    logic                  table_full;
    logic [BucketOutW-1:0] bucket;
  } out_beat_t;

  // One way of a bucket row as it sits in the table memory.
  typedef struct packed {
    logic        valid;
    logic [63:0] addrs;
    logic [31:0] ports;
    logic [31:0] id;
  } way_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic resolve;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_blocked;
  } ctrl_sts_t;

  // Folds the four address bytes and then the two port bytes, most significant
  // first. Only the low bits survive, which is all the bucket index needs.
  function automatic logic [HashW-1:0] endpoint_hash(logic [31:0] addr, logic [15:0] port);
    logic [8*HashBytes-1:0] bytes_v;
    logic [HashW-1:0]       h;
    bytes_v = {addr, port};
    h = '0;
    for (int i = HashBytes - 1; i >= 0; i--) begin
      h = h * HashMul + {8'h00, bytes_v[8*i +: 8]};
    end
    return h;
  endfunction

endpackage

@@ src/bft_ctrl.sv @@
// Controller of the bidirectional flow table: clearing pass, accept and resolve.
// Depends on bft_pkg for the command and status structs.
module bft_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output bft_pkg::ctrl_cmd_t    cmd_o,
  input  bft_pkg::ctrl_sts_t    sts_i
);

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StResolve
  } state_e;

  state_e state_q, state_d;
  logic   in_stall_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: begin
        if (sts_i.clear_last) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i) state_d = StResolve;
      end
      StResolve: begin
        if (!sts_i.out_blocked) state_d = StIdle;
      end
      default: state_d = StClear;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      in_stall_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_stall_q <= (state_d != StIdle);
    end
  end

  assign in_stall_o    = in_stall_q;
  assign cmd_o.clear   = (state_q == StClear);
  assign cmd_o.load    = (state_q == StIdle) && in_valid_i;
  assign cmd_o.resolve = (state_q == StResolve) && !sts_i.out_blocked;

endmodule

@@ src/bft_datapath.sv @@
// Datapath of the bidirectional flow table: hash, bucket memory, way compare,
// entry id counter and result register. Depends on bft_pkg.
module bft_datapath #(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned WAYS    = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bft_pkg::ctrl_cmd_t    cmd_i,
  output bft_pkg::ctrl_sts_t    sts_o,
  input  bft_pkg::in_beat_t     in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bft_pkg::out_beat_t    out_beat_o
);

  localparam int unsigned BktW = $clog2(BUCKETS);

  bft_pkg::way_t [WAYS-1:0] mem_q [BUCKETS];
  bft_pkg::way_t [WAYS-1:0] row_q;
  bft_pkg::way_t [WAYS-1:0] row_upd;
  bft_pkg::way_t [WAYS-1:0] mem_wdata;
  bft_pkg::in_beat_t        key_q;
  bft_pkg::out_beat_t       out_q, out_d;
  logic [BktW-1:0]          bkt_in, bkt_q, clr_cnt_q, mem_waddr;
  logic [bft_pkg::HashW-1:0] hash_sum, bkt_ext;
  logic [31:0]              next_id_q, hit_id;
  logic [63:0]              key_a, key_a_sw;
  logic [31:0]              key_p, key_p_sw;
  logic [WAYS-1:0]          hit_vec, free_vec, first_hit, first_free;
  logic                     hit, has_free, mem_we, create, out_valid_q;

  // Bucket of the beat on the input port; the row is read at the accepting edge.
  assign hash_sum = bft_pkg::endpoint_hash(in_beat_i.src_addr, in_beat_i.src_port)
                  + bft_pkg::endpoint_hash(in_beat_i.dst_addr, in_beat_i.dst_port)
                  + {8'h00, in_beat_i.protocol};
  assign bkt_in   = hash_sum[BktW-1:0];

  assign key_a    = {key_q.src_addr, key_q.dst_addr};
  assign key_a_sw = {key_q.dst_addr, key_q.src_addr};
  assign key_p    = {key_q.src_port, key_q.dst_port};
  assign key_p_sw = {key_q.dst_port, key_q.src_port};

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]  = row_q[w].valid &&
                    ((row_q[w].addrs == key_a && row_q[w].ports == key_p) ||
                     (row_q[w].addrs == key_a_sw && row_q[w].ports == key_p_sw));
      free_vec[w] = !row_q[w].valid;
    end
  end

  // Lowest set bit picks the first way in order.
  assign first_hit  = hit_vec & (~hit_vec + WAYS'(1));
  assign first_free = free_vec & (~free_vec + WAYS'(1));
  assign hit        = |hit_vec;
  assign has_free   = |free_vec;
  assign create     = !hit && has_free;

  always_comb begin
    hit_id  = '0;
    row_upd = row_q;
    for (int w = 0; w < WAYS; w++) begin
      if (first_hit[w]) hit_id = hit_id | row_q[w].id;
      if (first_free[w]) begin
        row_upd[w].valid = 1'b1;
        row_upd[w].addrs = key_a;
        row_upd[w].ports = key_p;
        row_upd[w].id    = next_id_q;
      end
    end
  end

  assign bkt_ext = bft_pkg::HashW'(bkt_q);

  always_comb begin
    out_d.flow_id    = hit ? hit_id : (has_free ? next_id_q : 32'd0);
    out_d.created    = create;
    out_d.table_full = !hit && !has_free;
    out_d.bucket     = bkt_ext[bft_pkg::BucketOutW-1:0];
  end

  assign mem_we    = cmd_i.clear || (cmd_i.resolve && create);
  assign mem_waddr = cmd_i.clear ? clr_cnt_q : bkt_q;
  assign mem_wdata = cmd_i.clear ? '0 : row_upd;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (cmd_i.load) begin
      row_q <= mem_q[bkt_in];
      key_q <= in_beat_i;
      bkt_q <= bkt_in;
    end
    if (cmd_i.resolve) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      next_id_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_cnt_q <= clr_cnt_q + BktW'(1);
      if (cmd_i.resolve && create) next_id_q <= next_id_q + 32'd1;
      if (cmd_i.resolve) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clear_last  = (clr_cnt_q == BktW'(BUCKETS - 1));
  assign sts_o.out_blocked = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_beat_o        = out_q;

endmodule

@@ src/bidirectional_flow_table.sv @@
// Top level of the bidirectional flow table: controller plus datapath.
// Depends on bft_pkg, bft_ctrl and bft_datapath.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    in_beat_i  (bft_pkg::in_beat_t)
//   out      output     out_valid_o / out_stall_i  out_beat_o (bft_pkg::out_beat_t)
//
// For a packet, the accepting edge reads its bucket row from the table memory;
// once the output register is free, the resolve edge compares all ways, writes
// the row back on a new entry and loads the result register.
// After reset a clearing pass writes one bucket row per cycle, every row in turn,
// with in_stall_o high.
// A stalled result holds in the output register; one more beat is taken in the
// meantime, and its compare waits until the output register frees up.
module bidirectional_flow_table #(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned WAYS    = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bft_pkg::in_beat_t   in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bft_pkg::out_beat_t  out_beat_o
);

  bft_pkg::ctrl_cmd_t cmd;
  bft_pkg::ctrl_sts_t sts;

  bft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  bft_datapath #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  a_resolve_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.resolve |-> !(out_valid_o && out_stall_i))
    else $error("result written while the output register was stalled");

  a_resolve_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.resolve |=> out_valid_o)
    else $error("resolved beat did not reach the output");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second beat accepted before the first was resolved");

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> (in_stall_o && !cmd.load))
    else $error("beat accepted during the clearing pass");

endmodule

@@ tb/bidirectional_flow_table_tb.sv @@
// Self-checking testbench for the bidirectional flow table: directed packets,
// then random traffic partly aimed at a few crowded buckets, scored by typed
// results or a predictor. Depends on bft_pkg and bidirectional_flow_table.
`timescale 1ns / 100ps

module bidirectional_flow_table_tb;

  localparam int unsigned NumBuckets    = 1024;
  localparam int unsigned NumWays       = 4;
  localparam int unsigned NumEntries    = NumBuckets * NumWays;
  localparam int unsigned RandomPackets = 800;
  localparam int unsigned PoolDepth     = 256;
  localparam int unsigned NumHot        = 4;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned SettleCycles  = 16;
  localparam int unsigned WatchdogLimit = 5000;
  localparam bit          KnownResult   = 1'b1;
  localparam bit          ByPredictor   = 1'b0;

  typedef struct {
    bft_pkg::in_beat_t  beat;
    bit                 typed;
    bft_pkg::out_beat_t result;
  } directed_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  bft_pkg::in_beat_t  in_beat_i;
  logic               out_valid_o;
  logic               out_stall_i;
  bft_pkg::out_beat_t out_beat_o;

  // Predicted flow table.
  bit          slot_used [NumEntries];
  logic [63:0] slot_addrs[NumEntries];
  logic [31:0] slot_ports[NumEntries];
  logic [31:0] slot_id   [NumEntries];
  logic [31:0] next_id;

  bft_pkg::out_beat_t pending_results[$];
  bft_pkg::in_beat_t  flow_pool[$];
  directed_row_t      directed_rows[$];
  int unsigned        hot_bucket[NumHot];

  int unsigned mismatches;
  int unsigned packets_sent;
  int unsigned results_checked;
  int unsigned new_flows;
  int unsigned flow_hits;
  int unsigned full_misses;
  bit          steady;
  bit          long_hold_req;

  bidirectional_flow_table #(
    .BUCKETS(NumBuckets),
    .WAYS   (NumWays)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] fold_endpoint(logic [31:0] addr, logic [15:0] port);
    logic [47:0] octets;
    logic [63:0] acc;
    octets = {addr, port};
    acc = '0;
    for (int i = 5; i >= 0; i--) begin
      acc = acc * 64'd13 + {56'd0, octets[8*i +: 8]};
    end
    return acc;
  endfunction

  function automatic int unsigned bucket_of(bft_pkg::in_beat_t b);
    logic [63:0] sum;
    sum = fold_endpoint(b.src_addr, b.src_port) + fold_endpoint(b.dst_addr, b.dst_port)
        + {56'd0, b.protocol};
    return int'(sum % NumBuckets);
  endfunction

  // Finds the packet's flow in either direction or claims the first free way.
  function automatic bft_pkg::out_beat_t lookup_flow(bft_pkg::in_beat_t b);
    int unsigned        bkt;
    int unsigned        e;
    int                 free_way;
    logic [63:0]        key_addrs;
    logic [63:0]        key_addrs_sw;
    logic [31:0]        key_ports;
    logic [31:0]        key_ports_sw;
    bft_pkg::out_beat_t r;
    bkt          = bucket_of(b);
    key_addrs    = {b.src_addr, b.dst_addr};
    key_addrs_sw = {b.dst_addr, b.src_addr};
    key_ports    = {b.src_port, b.dst_port};
    key_ports_sw = {b.dst_port, b.src_port};
    r            = '0;
    r.bucket     = bkt[bft_pkg::BucketOutW-1:0];
    free_way     = -1;
    for (int w = 0; w < NumWays; w++) begin
      e = bkt * NumWays + w;
      if (slot_used[e]) begin
        if ((slot_addrs[e] == key_addrs && slot_ports[e] == key_ports) ||
            (slot_addrs[e] == key_addrs_sw && slot_ports[e] == key_ports_sw)) begin
          r.flow_id = slot_id[e];
          return r;
        end
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    if (free_way < 0) begin
      r.table_full = 1'b1;
      return r;
    end
    e             = bkt * NumWays + free_way;
    slot_used[e]  = 1'b1;
    slot_addrs[e] = key_addrs;
    slot_ports[e] = key_ports;
    slot_id[e]    = next_id;
    r.flow_id     = next_id;
    r.created     = 1'b1;
    next_id       = next_id + 32'd1;
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Replays of known flows in either direction (the largest share), new flows
  // steered into a few crowded buckets so they fill up, the rest random headers.
  function automatic bft_pkg::in_beat_t gen_packet();
    bft_pkg::in_beat_t b;
    int unsigned       r;
    int unsigned       target;
    int unsigned       diff;
    r = $urandom_range(0, 99);
    if (r < 45 && flow_pool.size() != 0) begin
      b = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
      if ($urandom_range(0, 1) == 1) begin
        b = '{b.dst_addr, b.src_addr, b.dst_port, b.src_port, b.protocol};
      end
      if ($urandom_range(0, 9) == 0) b.protocol = 8'($urandom_range(0, 255));
      return b;
    end
    b.src_addr = $urandom;
    b.dst_addr = $urandom;
    b.src_port = 16'($urandom_range(0, 65535));
    b.dst_port = 16'($urandom_range(0, 65535));
    b.protocol = 8'($urandom_range(0, 255));
    if (r < 75) begin
      target     = hot_bucket[$urandom_range(0, NumHot - 1)];
      b.protocol = '0;
      do begin
        b.src_addr = $urandom;
        diff = (target + NumBuckets - bucket_of(b)) % NumBuckets;
      end while (diff > 255);
      b.protocol = diff[7:0];
    end
    if (flow_pool.size() >= PoolDepth) flow_pool.delete($urandom_range(0, PoolDepth - 1));
    flow_pool.push_back(b);
    return b;
  endfunction

  task automatic add_row(input logic [31:0] sa, input logic [31:0] da, input logic [15:0] sp,
                         input logic [15:0] dp, input logic [7:0] pr, input bit typed,
                         input logic [31:0] id, input logic cr, input logic full,
                         input logic [bft_pkg::BucketOutW-1:0] bkt);
    directed_row_t row;
    row.beat   = '{sa, da, sp, dp, pr};
    row.typed  = typed;
    row.result = '{id, cr, full, bkt};
    directed_rows.push_back(row);
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_result(input bft_pkg::out_beat_t got);
    bft_pkg::out_beat_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result beat with no packet pending (id %0d)", got.flow_id));
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (got.flow_id !== want.flow_id)
      report_mismatch($sformatf("flow_id %0d, expected %0d", got.flow_id, want.flow_id));
    if (got.created !== want.created)
      report_mismatch($sformatf("created %0b, expected %0b", got.created, want.created));
    if (got.table_full !== want.table_full)
      report_mismatch($sformatf("table_full %0b, expected %0b", got.table_full,
                                want.table_full));
    if (got.bucket !== want.bucket)
      report_mismatch($sformatf("bucket %0d, expected %0d", got.bucket, want.bucket));
  endtask

  // Offers one packet and returns at the edge that takes it. A typed result
  // replaces the predicted one, but the predictor still sees the packet.
  task automatic offer_packet(input bft_pkg::in_beat_t b, input bit typed,
                              input bft_pkg::out_beat_t typed_res);
    bft_pkg::out_beat_t predicted;
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    predicted = lookup_flow(b);
    if (predicted.created) new_flows++;
    else if (predicted.table_full) full_misses++;
    else flow_hits++;
    pending_results.push_back(typed ? typed_res : predicted);
    packets_sent++;
  endtask

  task automatic idle_sender(input int unsigned cycles);
    if (cycles != 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_result(out_beat_o);
      if (long_hold_req) begin
        stall_left    = LongHold;
        long_hold_req = 1'b0;
      end else if (stall_left == 0 && !steady) begin
        stall_left = gap_len();
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WatchdogLimit) begin
        $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                 quiet, pending_results.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_valid_i    = 1'b0;
    in_beat_i     = '0;
    rst_ni        = 1'b0;
    steady        = 1'b0;
    long_hold_req = 1'b0;
    next_id       = '0;
    foreach (hot_bucket[i]) hot_bucket[i] = $urandom_range(0, NumBuckets - 1);

    // Empty table, then repeats and the reverse direction.
    add_row(32'h0, 32'h0, 16'h0, 16'h0, 8'h00, KnownResult, 32'd0, 1'b1, 1'b0, 10'd0);
    add_row(32'h0, 32'h0, 16'h0, 16'h0, 8'h00, KnownResult, 32'd0, 1'b0, 1'b0, 10'd0);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
            KnownResult, 32'd1, 1'b1, 1'b0, 10'd651);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
            KnownResult, 32'd1, 1'b0, 1'b0, 10'd651);
    // Five distinct flows that all hash to bucket 10: the fifth finds it full.
    add_row(32'h0, 32'h0, 16'h0, 16'd1, 8'd9, KnownResult, 32'd2, 1'b1, 1'b0, 10'd10);
    add_row(32'h0, 32'h0, 16'h0, 16'd2, 8'd8, KnownResult, 32'd3, 1'b1, 1'b0, 10'd10);
    add_row(32'h0, 32'h0, 16'h0, 16'd3, 8'd7, KnownResult, 32'd4, 1'b1, 1'b0, 10'd10);
    add_row(32'h0, 32'h0, 16'h0, 16'd4, 8'd6, KnownResult, 32'd5, 1'b1, 1'b0, 10'd10);
    add_row(32'h0, 32'h0, 16'h0, 16'd5, 8'd5, KnownResult, 32'd0, 1'b0, 1'b1, 10'd10);
    add_row(32'h0, 32'h0, 16'd1, 16'h0, 8'd9, KnownResult, 32'd2, 1'b0, 1'b0, 10'd10);
    add_row(32'h0, 32'h0, 16'h0, 16'd5, 8'd5, KnownResult, 32'd0, 1'b0, 1'b1, 10'd10);
    // Same addresses and ports under another protocol move to another bucket.
    add_row(32'h0, 32'h0, 16'h0, 16'd1, 8'd100, KnownResult, 32'd6, 1'b1, 1'b0, 10'd101);
    add_row(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555, 8'hAA, ByPredictor, 0, 0, 0, 0);
    add_row(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 8'hAA, ByPredictor, 0, 0, 0, 0);
    add_row(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 8'h55, ByPredictor, 0, 0, 0, 0);
    add_row(32'h8000_0000, 32'h0000_0001, 16'h8000, 16'h0001, 8'h80, ByPredictor, 0, 0, 0, 0);
    add_row(32'h0000_0001, 32'h8000_0000, 16'h0001, 16'h8000, 8'h80, ByPredictor, 0, 0, 0, 0);
    add_row(32'h7FFF_FFFF, 32'hFFFF_FFFE, 16'h7FFF, 16'hFFFE, 8'h7F, ByPredictor, 0, 0, 0, 0);
    add_row(32'hC0A8_0001, 32'h0A00_0001, 16'h1234, 16'h0050, 8'h06, ByPredictor, 0, 0, 0, 0);
    add_row(32'h0A00_0001, 32'hC0A8_0001, 16'h0050, 16'h1234, 8'h06, ByPredictor, 0, 0, 0, 0);
    add_row(32'hC0A8_0001, 32'h0A00_0001, 16'h1234, 16'h0050, 8'h11, ByPredictor, 0, 0, 0, 0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_packet(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].result);
      idle_sender(gap_len());
    end
    wait_for_results();

    for (int i = 0; i < RandomPackets; i++) begin
      steady = (i % 200) >= 150;
      // Hold the result side off for a long stretch while packets keep coming,
      // and later let the table drain completely before going on.
      if (i == 300) long_hold_req = 1'b1;
      if (i == 500) wait_for_results();
      offer_packet(gen_packet(), ByPredictor, '0);
      if (!steady) idle_sender(gap_len());
    end
    steady = 1'b0;

    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);

    $display("%0d packets sent, %0d results checked", packets_sent, results_checked);
    $display("%0d new flows, %0d hits in either direction, %0d misses on a full bucket",
             new_flows, flow_hits, full_misses);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
